FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define GFAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// check on every clock edge, reset included
`define GFAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GFAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define GFAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, constants and GF(2^8) functions (polynomial 0x11D).
// ----------------------------------------------------------------------------
`default_nettype none

package gfau_pkg;

    localparam int STEP_STAGES = 6;
    localparam int NUM_STAGES  = STEP_STAGES + 2;

    typedef enum logic [1:0] {
        CMD_CLMUL = 2'd0,
        CMD_MUL   = 2'd1,
        CMD_SQR   = 2'd2,
        CMD_INV   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  pw;
        logic [14:0] acc;
    } t_gfau_item;

    function automatic logic [14:0] gf_poly_mul(input logic [7:0] a, input logic [7:0] b);
        logic [14:0] acc;
        acc = 15'd0;
        for (int k = 0; k < 8; k++) begin
            if (a[k]) begin
                acc = acc ^ ({7'd0, b} << k);
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_fold(input logic [14:0] v);
        logic [6:0]  hi;
        logic [10:0] t;
        logic [2:0]  h2;
        logic [7:0]  u;
        hi = v[14:8];
        t  = {3'd0, v[7:0]} ^ {4'd0, hi} ^ {2'd0, hi, 2'd0}
           ^ {1'd0, hi, 3'd0} ^ {hi, 4'd0};
        h2 = t[10:8];
        u  = t[7:0] ^ {5'd0, h2} ^ {3'd0, h2, 2'd0}
           ^ {2'd0, h2, 3'd0} ^ {1'd0, h2, 4'd0};
        return u;
    endfunction

    function automatic logic [14:0] gf_spread(input logic [7:0] a);
        logic [14:0] s;
        s = 15'd0;
        for (int k = 0; k < 8; k++) begin
            s[2*k] = a[k];
        end
        return s;
    endfunction

    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        return gf_fold(gf_spread(a));
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        return gf_fold(gf_poly_mul(a, b));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gfau_step.sv
// ----------------------------------------------------------------------------
// gfau_step
// One pipeline stage: square-and-multiply for inverse, fold for multiply
// and square, pass-through for carry-less multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_step (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  gfau_pkg::t_gfau_item i_item,
    output logic                 o_valid,
    output gfau_pkg::t_gfau_item o_item
);

    logic                 r_vld;
    gfau_pkg::t_gfau_item r_item;
    gfau_pkg::t_gfau_item n_item;
    logic [7:0]           w_pw;

    always_comb begin
        n_item = i_item;
        w_pw   = gfau_pkg::gf_sq(i_item.pw);
        unique case (i_item.cmd)
            gfau_pkg::CMD_CLMUL: begin
                n_item.acc = i_item.acc;
            end
            gfau_pkg::CMD_MUL, gfau_pkg::CMD_SQR: begin
                n_item.acc = {7'd0, gfau_pkg::gf_fold(i_item.acc)};
            end
            gfau_pkg::CMD_INV: begin
                n_item.pw  = w_pw;
                n_item.acc = {7'd0, gfau_pkg::gf_mul(i_item.acc[7:0], w_pw)};
            end
            default: begin
                n_item = i_item;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: hw/rtl/gf256_arith_unit.sv
// ----------------------------------------------------------------------------
// gf256_arith_unit
// GF(2^8) arithmetic unit (poly 0x11D): clmul, multiply, square, inverse.
// ----------------------------------------------------------------------------
// Takes one request per clock and presents each result on the output, in order,
// when the output is not stalled. The depth is set by the inverse, a^254,
// built as seven square-and-multiply steps: one in the second stage and six in
// a chain of step stages; the other commands ride the same eight-stage
// pipeline. Each stage advances when it is empty or the next one does, so a
// stall on the output fills bubbles before pushing back on the input.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gf256_arith_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // [7:0] operand_a, [15:8] operand_b
    input  wire  [1:0]  i_s_axis_tuser,   // [1:0] command
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [14:0] result, [15] zero
);

    localparam int NS = gfau_pkg::NUM_STAGES;
    localparam int SS = gfau_pkg::STEP_STAGES;

    logic [NS-1:0]        w_vld;
    logic [NS-1:0]        w_en;
    gfau_pkg::t_gfau_item w_item [SS+1];

    logic                 r_a_vld;
    gfau_pkg::t_cmd       r_a_cmd;
    logic [7:0]           r_a_a;
    logic [7:0]           r_a_b;
    logic                 r_b_vld;
    gfau_pkg::t_gfau_item r_b_item;
    gfau_pkg::t_gfau_item n_b_item;

    always_comb begin
        w_en[NS-1] = !w_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !w_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en[0]) begin
            r_a_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_cmd <= gfau_pkg::t_cmd'(i_s_axis_tuser);
            r_a_a   <= i_s_axis_tdata[7:0];
            r_a_b   <= i_s_axis_tdata[15:8];
        end
    end

    always_comb begin
        n_b_item.cmd = r_a_cmd;
        n_b_item.pw  = r_a_a;
        n_b_item.acc = 15'd0;
        unique case (r_a_cmd)
            gfau_pkg::CMD_CLMUL, gfau_pkg::CMD_MUL: begin
                n_b_item.acc = gfau_pkg::gf_poly_mul(r_a_a, r_a_b);
            end
            gfau_pkg::CMD_SQR: begin
                n_b_item.acc = gfau_pkg::gf_spread(r_a_a);
            end
            gfau_pkg::CMD_INV: begin
                n_b_item.pw  = gfau_pkg::gf_sq(r_a_a);
                n_b_item.acc = {7'd0, gfau_pkg::gf_sq(r_a_a)};
            end
            default: begin
                n_b_item.acc = 15'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en[1]) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b_item <= n_b_item;
        end
    end

    assign w_vld[0]  = r_a_vld;
    assign w_vld[1]  = r_b_vld;
    assign w_item[0] = r_b_item;

    for (genvar g = 0; g < SS; g++) begin : g_step
        gfau_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g+2]),
            .i_valid (w_vld[g+1]),
            .i_item  (w_item[g]),
            .o_valid (w_vld[g+2]),
            .o_item  (w_item[g+1])
        );
    end

    assign o_m_axis_tvalid = w_vld[NS-1];
    assign o_m_axis_tdata  = {1'b0, w_item[SS].acc};

    `GFAU_ASSERT(a_field_hi_zero, i_clk, i_rst_n, (o_m_axis_tvalid && w_item[SS].cmd != gfau_pkg::CMD_CLMUL) |-> (o_m_axis_tdata[14:8] == 7'd0), "field result wider than a byte")
    `GFAU_ASSERT(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready |-> (&w_vld), "input stalled with a bubble in the pipeline")
    `GFAU_ASSERT_ALWAYS(a_rst_flush, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

endmodule

`default_nettype wire
